>>> hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/hnm_pkg.sv
package hnm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_WID_W  = 12;
	localparam int CFG_HGT_W  = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int PIX_W  = 8;
	localparam int DIFF_W = 9;
	localparam int COL_W  = 11;
	localparam int ROW_W  = 12;
	localparam int NS_W   = 16;
	localparam int NY_W   = 15;
	localparam int Q_W    = 15;
	localparam int LEN_W  = 17;

	localparam logic [Q_W-1:0] Q_ONE = 15'd16384;

	typedef logic [1:0] line_t;

	// one normal request between front and back
	typedef struct packed {
		logic signed [DIFF_W-1:0] a;
		logic signed [DIFF_W-1:0] b;
		logic [COL_W-1:0]         col;
		logic [ROW_W-1:0]         row;
		logic                     done;
	} qitem_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {F_IDLE, F_READ, F_PUSH} front_state_t;
	typedef enum logic [2:0] {B_IDLE, B_LEN, B_SQ, B_CMP, B_HOLD} back_state_t;

	// line stores rotate modulo three
	function automatic line_t line_next(line_t l);
		line_t r;
		r = (l == 2'd2) ? 2'd0 : line_t'(l + 2'd1);
		return r;
	endfunction

	function automatic line_t line_prev(line_t l);
		line_t r;
		r = (l == 2'd0) ? 2'd2 : line_t'(l - 2'd1);
		return r;
	endfunction

endpackage

>>> hw/rtl/hnm_if.sv
interface hnm_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] pixel;
	modport source (output valid, op, pixel, input ready);
	modport sink (input valid, op, pixel, output ready);
endinterface

interface hnm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normal_x;
	logic [14:0]        normal_y;
	logic signed [15:0] normal_z;
	logic [10:0]        column;
	logic [11:0]        row;
	logic               image_done;
	modport source (output valid, normal_x, normal_y, normal_z, column, row, image_done,
		input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, column, row, image_done,
		output ready);
endinterface

>>> hw/rtl/hnm_ram.sv
module hnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/hnm_front.sv
module hnm_front import hnm_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hnm_in_if.sink                in_ch,
	output logic                  push,
	output qitem_t                push_item,
	input  qstat_t                qstat
);

	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = 3 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	front_state_t state_q, state_nxt;

	logic [CFG_WID_W-1:0] width_q;
	logic [CFG_HGT_W-1:0] height_q;
	logic [CW-1:0]        eff_w;
	logic [RW-1:0]        eff_h;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] dcol_q;
	line_t         rot_q;
	logic          drain_q;
	logic [2:0]    step_q;

	line_t         j_line_q, j_dline_q, j_uline_q;
	logic          j_hasd_q, j_hasu_q, j_done_q, j_second_q;
	logic [CW-1:0] j_col_q;
	logic [RW-1:0] j_row_q;
	logic [PIX_W-1:0] samp_q [5];

	logic          accept, is_drain, drain_ok, pix_ok, pix_emit, job_start;
	logic          drain_last, col_last, row_last;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [PIX_W-1:0] ram_rdata;
	line_t         rd_line;
	logic [CW-1:0] rd_col;

	function automatic logic [AW-1:0] line_base(line_t l);
		logic [AW-1:0] r;
		unique case (l)
			2'd0:    r = '0;
			2'd1:    r = AW'(MAX_WIDTH);
			default: r = AW'(2 * MAX_WIDTH);
		endcase
		return r;
	endfunction

	// clamp the configured size
	always_comb begin
		if (width_q < 12'd2) begin
			eff_w = CW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(width_q);
		end
		if (height_q < 13'd2) begin
			eff_h = RW'(2);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = RW'(MAX_HEIGHT);
		end else begin
			eff_h = RW'(height_q);
		end
	end

	// classify the request
	assign accept     = in_ch.valid && in_ch.ready;
	assign is_drain   = (in_ch.op == OP_DRAIN);
	assign drain_ok   = drain_q && (dcol_q < eff_w);
	assign pix_ok     = !drain_q && (col_q < eff_w) && (row_q < eff_h);
	assign pix_emit   = pix_ok && (row_q != '0) && (col_q != '0);
	assign job_start  = accept && (is_drain ? drain_ok : pix_emit);
	assign drain_last = (dcol_q == eff_w - CW'(1));
	assign col_last   = (col_q == eff_w - CW'(1));
	assign row_last   = (row_q == eff_h - RW'(1));

	// line store write
	assign ram_we    = accept && !is_drain && pix_ok;
	assign ram_waddr = line_base(rot_q) + AW'(col_q);

	// neighbor fetch order: centre, left, right, down, up
	always_comb begin
		rd_line = j_line_q;
		rd_col  = j_col_q;
		unique case (step_q)
			3'd0: begin
			end
			3'd1: begin
				if (j_col_q != '0) rd_col = j_col_q - CW'(1);
			end
			3'd2: begin
				if ((CW+1)'(j_col_q) + (CW+1)'(1) < (CW+1)'(eff_w)) rd_col = j_col_q + CW'(1);
			end
			3'd3: begin
				if (j_hasd_q) rd_line = j_dline_q;
			end
			default: begin
				if (j_hasu_q) rd_line = j_uline_q;
			end
		endcase
	end
	assign ram_raddr = line_base(rd_line) + AW'(rd_col);

	hnm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_ch.pixel),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (job_start) state_nxt = F_READ;
			end
			F_READ: begin
				if (step_q == 3'd5) state_nxt = F_PUSH;
			end
			F_PUSH: begin
				if (!qstat.full) state_nxt = j_second_q ? F_READ : F_IDLE;
			end
			default: state_nxt = F_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ch.ready = (state_q == F_IDLE);
		ram_re      = (state_q == F_READ) && (step_q < 3'd5);
		push        = (state_q == F_PUSH) && !qstat.full;
	end

	// request toward the back
	always_comb begin
		push_item.a    = $signed({1'b0, samp_q[1]}) - $signed({1'b0, samp_q[2]});
		push_item.b    = $signed({1'b0, samp_q[3]}) - $signed({1'b0, samp_q[4]});
		push_item.col  = COL_W'(j_col_q);
		push_item.row  = ROW_W'(j_row_q);
		push_item.done = j_done_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			width_q  <= 12'd256;
			height_q <= 13'd256;
			col_q    <= '0;
			row_q    <= '0;
			dcol_q   <= '0;
			rot_q    <= 2'd0;
			drain_q  <= 1'b0;
			step_q   <= '0;
		end else begin
			state_q <= state_nxt;
			priority if (cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
				cfg_index == REG_IMAGE_HEIGHT)) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_q <= cfg_data[CFG_WID_W-1:0];
				end else begin
					height_q <= cfg_data;
				end
				col_q   <= '0;
				row_q   <= '0;
				dcol_q  <= '0;
				rot_q   <= 2'd0;
				drain_q <= 1'b0;
			end else if (accept && is_drain && drain_ok) begin
				step_q <= '0;
				if (drain_last) begin
					col_q   <= '0;
					row_q   <= '0;
					dcol_q  <= '0;
					rot_q   <= 2'd0;
					drain_q <= 1'b0;
				end else begin
					dcol_q <= dcol_q + CW'(1);
				end
			end else if (accept && !is_drain && pix_ok) begin
				step_q <= '0;
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						drain_q <= 1'b1;
						dcol_q  <= '0;
					end else begin
						row_q <= row_q + RW'(1);
						rot_q <= line_next(rot_q);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (state_q == F_READ) begin
				step_q <= step_q + 3'd1;
			end else if (push) begin
				step_q <= '0;
			end
		end
	end

	// job payload and fetched samples
	always_ff @(posedge clk) begin
		if (accept && is_drain && drain_ok) begin
			j_line_q   <= rot_q;
			j_dline_q  <= line_prev(rot_q);
			j_uline_q  <= rot_q;
			j_hasd_q   <= 1'b1;
			j_hasu_q   <= 1'b0;
			j_col_q    <= dcol_q;
			j_row_q    <= eff_h - RW'(1);
			j_done_q   <= drain_last;
			j_second_q <= 1'b0;
		end else if (accept && !is_drain && pix_emit) begin
			j_line_q   <= line_prev(rot_q);
			j_dline_q  <= line_next(rot_q);
			j_uline_q  <= rot_q;
			j_hasd_q   <= (row_q >= RW'(2));
			j_hasu_q   <= 1'b1;
			j_col_q    <= col_q - CW'(1);
			j_row_q    <= row_q - RW'(1);
			j_done_q   <= 1'b0;
			j_second_q <= col_last;
		end else if (push && j_second_q) begin
			j_col_q    <= j_col_q + CW'(1);
			j_second_q <= 1'b0;
		end
		if (state_q == F_READ) begin
			unique case (step_q)
				3'd1:    samp_q[0] <= ram_rdata;
				3'd2:    samp_q[1] <= ram_rdata;
				3'd3:    samp_q[2] <= ram_rdata;
				3'd4:    samp_q[3] <= ram_rdata;
				3'd5:    samp_q[4] <= ram_rdata;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/hnm_fifo.sv
module hnm_fifo import hnm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	input  logic   pop,
	output qitem_t pop_item,
	output qstat_t stat
);

	qitem_t     mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign pop_item   = mem_q[rp_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

endmodule

>>> hw/rtl/hnm_back.sv
module hnm_back import hnm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  qstat_t qstat,
	output logic   pop,
	input  qitem_t pop_item,
	hnm_out_if.source out_ch
);

	back_state_t state_q, state_nxt;

	logic signed [DIFF_W-1:0] a_q, b_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             done_q;
	logic [15:0]      msq_q [3];
	logic [LEN_W-1:0] len_q;
	logic [Q_W-1:0]   q_q [3];
	logic [3:0]       bit_q;
	logic [31:0]      tsq_q [3];
	logic             out_v_q;

	logic [7:0]     pa, pb;
	logic [7:0]     mag [3];
	logic [Q_W-1:0] cand [3];
	logic [15:0]    t [3];
	logic           ok [3];
	logic           load;

	// magnitudes of the incoming differences
	assign pa     = pop_item.a[DIFF_W-1] ? 8'(-pop_item.a) : 8'(pop_item.a);
	assign pb     = pop_item.b[DIFF_W-1] ? 8'(-pop_item.b) : 8'(pop_item.b);
	assign mag[0] = pa;
	assign mag[1] = 8'd8;
	assign mag[2] = pb;

	// one candidate bit per lane, tested as (2q-1)^2 * len2 <= m^2 * 2^30
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cand[i] = q_q[i] | (Q_W'(1) << bit_q);
			t[i]    = {cand[i], 1'b0} - 16'd1;
			ok[i]   = (cand[i] <= Q_ONE) &&
				((49'(tsq_q[i]) * 49'(len_q)) <= (49'(msq_q[i]) << 30));
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE:  if (!qstat.empty) state_nxt = B_LEN;
			B_LEN:   state_nxt = B_SQ;
			B_SQ:    state_nxt = B_CMP;
			B_CMP:   state_nxt = (bit_q == 4'd0) ? B_HOLD : B_SQ;
			B_HOLD:  if (!out_v_q || out_ch.ready) state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop  = (state_q == B_IDLE) && !qstat.empty;
		load = (state_q == B_HOLD) && (!out_v_q || out_ch.ready);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
			bit_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == B_LEN) begin
				bit_q <= 4'd14;
			end else if (state_q == B_CMP && bit_q != 4'd0) begin
				bit_q <= bit_q - 4'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			a_q    <= pop_item.a;
			b_q    <= pop_item.b;
			col_q  <= pop_item.col;
			row_q  <= pop_item.row;
			done_q <= pop_item.done;
			for (int i = 0; i < 3; i++) begin
				msq_q[i] <= {8'b0, mag[i]} * {8'b0, mag[i]};
			end
		end
		if (state_q == B_LEN) begin
			len_q <= LEN_W'(msq_q[0]) + LEN_W'(msq_q[2]) + LEN_W'(64);
			for (int i = 0; i < 3; i++) q_q[i] <= '0;
		end
		if (state_q == B_SQ) begin
			for (int i = 0; i < 3; i++) tsq_q[i] <= {16'b0, t[i]} * {16'b0, t[i]};
		end
		if (state_q == B_CMP) begin
			for (int i = 0; i < 3; i++) begin
				if (ok[i]) q_q[i] <= cand[i];
			end
		end
		if (load) begin
			out_ch.normal_x   <= a_q[DIFF_W-1] ? NS_W'(16'd0 - 16'(q_q[0])) : NS_W'(q_q[0]);
			out_ch.normal_y   <= q_q[1];
			out_ch.normal_z   <= b_q[DIFF_W-1] ? NS_W'(16'd0 - 16'(q_q[2])) : NS_W'(q_q[2]);
			out_ch.column     <= col_q;
			out_ch.row        <= row_q;
			out_ch.image_done <= done_q;
		end
	end

	assign out_ch.valid = out_v_q;

endmodule

>>> hw/rtl/heightmap_normal_generator.sv
// Streaming normal map from a height image.
// cfg_we/cfg_index/cfg_data write image_width (index 0) and image_height
// (index 1); a write restarts the stream and must be made while the block is
// idle (not enforced). in_ch carries one request: op 0 is a height pixel in
// raster order, op 1 drains one normal of the last row. out_ch carries one
// unit normal in Q1.14 with its column, row and an end-of-image flag.
// A pixel of row r >= 1, column x >= 1 yields the normal of (x-1, r-1), and
// the last column yields a second one; after the last row, one drain per
// normal of that row.
// Each normal costs five reads through the single read port and a queue
// push in the front (a pixel also writes the line store), and 15 bit steps
// in the back for the three lanes of the divide-free unit-length search;
// the front can take the next request while the back searches, so that
// search sets the sustained rate.
// A two-entry queue sits between front and back; when the receiver stalls,
// the result holds in the output register, the back then the queue fill, and
// in_ch.ready drops once the front cannot push.
// Reset clears counters and size registers (256 x 256); line stores are not
// cleared and need no clearing pass.
module heightmap_normal_generator import hnm_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hnm_in_if.sink                in_ch,
	hnm_out_if.source             out_ch
);

	`include "assert_macros.svh"

	logic   push, pop;
	qitem_t push_item, pop_item;
	qstat_t qstat;

	hnm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.push      (push),
		.push_item (push_item),
		.qstat     (qstat)
	);

	hnm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (qstat)
	);

	hnm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop      (pop),
		.pop_item (pop_item),
		.out_ch   (out_ch)
	);

	`ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !qstat.full)
	`ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !qstat.empty)
	`ASSERT_NEXT(a_push_fills, clk, arst_n, push, !qstat.empty)
	`ASSERT_IMPL(a_unit_y, clk, arst_n, out_ch.valid, out_ch.normal_y <= 15'd16384)

endmodule
